// ----- hw/rtl/fnu_pkg.sv -----
// ----------------------------------------------------------------------------
// fnu_pkg
// Shared widths, beat types and arithmetic step functions for the face
// unit-normal and boundary-tag pipeline.
// ----------------------------------------------------------------------------
package fnu_pkg;

  // Field widths
  localparam int COORD_BITS = 24;
  localparam int TAG_BITS   = 4;

  // Datapath widths derived from the coordinate width
  localparam int EDGE_W   = COORD_BITS + 1;
  localparam int PROD_W   = 2 * EDGE_W;
  localparam int CROSS_W  = PROD_W + 1;
  localparam int TOP_W    = $clog2(CROSS_W + 1);
  localparam int A_W      = 30;             // normalized magnitude, top bit at A_W-1
  localparam int SQ_W     = 2 * A_W;
  localparam int SUM_W    = SQ_W + 2;
  localparam int RAD_W    = SUM_W + 2;      // radicand padded to an even bit pair count
  localparam int ROOT_W   = RAD_W / 2;
  localparam int LEN_W    = A_W + 1;        // floor(sqrt(sum)) always fits here
  localparam int REM_W    = ROOT_W + 4;
  localparam int Q_W      = 16;
  localparam int R_W      = LEN_W + 1;

  // Pipeline shape of the iterative units
  localparam int SQ_PER     = 2;
  localparam int SQ_STAGES  = ROOT_W / SQ_PER;
  localparam int DIV_PER    = 2;
  localparam int DIV_STAGES = Q_W / DIV_PER;

  // Override rules: index order is -x, +x, -y, +y, -z, +z
  localparam int NUM_RULES = 6;
  localparam int CFG_IDX_W = 3;

  localparam logic [Q_W-1:0] Q15_MAX       = 16'd32767;
  localparam logic [Q_W-1:0] BEYOND_THRESH = 16'd19661;  // 0.6 in Q1.15, rounded up

  // Input beat: one face
  typedef struct packed {
    logic signed [COORD_BITS-1:0] p0_x;
    logic signed [COORD_BITS-1:0] p0_y;
    logic signed [COORD_BITS-1:0] p0_z;
    logic signed [COORD_BITS-1:0] p1_x;
    logic signed [COORD_BITS-1:0] p1_y;
    logic signed [COORD_BITS-1:0] p1_z;
    logic signed [COORD_BITS-1:0] p2_x;
    logic signed [COORD_BITS-1:0] p2_y;
    logic signed [COORD_BITS-1:0] p2_z;
    logic [TAG_BITS-1:0]          tag_in;
  } face_in_t;

  // Output beat: unit normal and tag
  typedef struct packed {
    logic signed [Q_W-1:0] unit_nx;
    logic signed [Q_W-1:0] unit_ny;
    logic signed [Q_W-1:0] unit_nz;
    logic [TAG_BITS-1:0]   tag_out;
    logic                  degenerate;
  } face_out_t;

  // Per-face data riding alongside the square root and divide
  typedef struct packed {
    logic [2:0][A_W-1:0] a;
    logic [2:0]          neg;
    logic [TAG_BITS-1:0] tag;
    logic                degen;
  } side_t;

  typedef struct packed {
    logic [RAD_W-1:0]  rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    side_t             side;
  } sqrt_st_t;

  typedef struct packed {
    logic [2:0][R_W-1:0] r;
    logic [2:0][Q_W-1:0] q;
    logic [LEN_W-1:0]    len;
    side_t               side;
  } div_st_t;

  // Edge vector component b - a, one bit wider than a coordinate
  function automatic logic signed [EDGE_W-1:0] diff_of(
    input logic signed [COORD_BITS-1:0] b,
    input logic signed [COORD_BITS-1:0] a
  );
    diff_of = $signed({b[COORD_BITS-1], b}) - $signed({a[COORD_BITS-1], a});
  endfunction

  // Index of the top set bit plus one, zero for zero
  function automatic logic [TOP_W-1:0] bitlen(input logic [CROSS_W-1:0] m);
    logic [TOP_W-1:0] n;
    n = '0;
    for (int i = 0; i < CROSS_W; i++) begin
      if (m[i]) begin
        n = TOP_W'(i + 1);
      end
    end
    bitlen = n;
  endfunction

  // Shift so a magnitude of bit length top lands with its top bit at A_W-1
  function automatic logic [A_W-1:0] scale_mag(
    input logic [CROSS_W-1:0] m,
    input logic [TOP_W-1:0]   top
  );
    logic [TOP_W-1:0] sh;
    if (top > TOP_W'(A_W)) begin
      sh = top - TOP_W'(A_W);
      scale_mag = A_W'(m >> sh);
    end else begin
      sh = TOP_W'(A_W) - top;
      scale_mag = A_W'(m << sh);
    end
  endfunction

  // One digit of the restoring square root
  function automatic sqrt_st_t sqrt_step(input sqrt_st_t st);
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    sqrt_st_t         nx;
    nx     = st;
    rem_sh = {st.rem[REM_W-3:0], st.rad[RAD_W-1 -: 2]};
    trial  = REM_W'({st.root, 2'b01});
    if (rem_sh >= trial) begin
      nx.rem  = rem_sh - trial;
      nx.root = {st.root[ROOT_W-2:0], 1'b1};
    end else begin
      nx.rem  = rem_sh;
      nx.root = {st.root[ROOT_W-2:0], 1'b0};
    end
    nx.rad = {st.rad[RAD_W-3:0], 2'b00};
    sqrt_step = nx;
  endfunction

  // One quotient bit of the restoring divide, all three lanes
  function automatic div_st_t div_step(input div_st_t st);
    logic           ge;
    logic [R_W-1:0] rest;
    div_st_t        nx;
    nx = st;
    for (int i = 0; i < 3; i++) begin
      ge       = st.r[i] >= R_W'(st.len);
      rest     = ge ? (st.r[i] - R_W'(st.len)) : st.r[i];
      nx.q[i]  = {st.q[i][Q_W-2:0], ge};
      nx.r[i]  = {rest[R_W-2:0], 1'b0};
    end
    div_step = nx;
  endfunction

endpackage

// ----- hw/rtl/fnu_cross.sv -----
// ----------------------------------------------------------------------------
// fnu_cross
// Edge vectors, exact cross product and sign/magnitude split; four stages.
// ----------------------------------------------------------------------------
module fnu_cross (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             up_valid,
  output logic                             up_ready,
  input  fnu_pkg::face_in_t                face,
  output logic                             dn_valid,
  input  logic                             dn_ready,
  output logic [2:0][fnu_pkg::CROSS_W-1:0] mag,
  output logic [2:0]                       neg,
  output logic [fnu_pkg::TAG_BITS-1:0]     tag
);
  import fnu_pkg::*;

  localparam int NS = 4;

  logic [NS-1:0] vld;
  logic [NS:0]   rdy;
  logic [NS-1:0] vin;

  logic signed [EDGE_W-1:0]  e1x, e1y, e1z, e2x, e2y, e2z;
  logic signed [PROD_W-1:0]  prod [6];
  logic signed [CROSS_W-1:0] cdiff [3];
  logic [TAG_BITS-1:0]       tag_s [NS];

  // Stage-local ready chain: a stage takes a beat when empty or draining
  always_comb begin
    rdy[NS] = dn_ready;
    for (int k = NS - 1; k >= 0; k--) begin
      rdy[k] = ~vld[k] | rdy[k+1];
    end
  end

  assign vin = {vld[NS-2:0], up_valid};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (rdy[k]) begin
          vld[k] <= vin[k];
        end
      end
    end
  end

  // Stage 0: edges v1-v0 and v2-v0
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      e1x      <= diff_of(face.p1_x, face.p0_x);
      e1y      <= diff_of(face.p1_y, face.p0_y);
      e1z      <= diff_of(face.p1_z, face.p0_z);
      e2x      <= diff_of(face.p2_x, face.p0_x);
      e2y      <= diff_of(face.p2_y, face.p0_y);
      e2z      <= diff_of(face.p2_z, face.p0_z);
      tag_s[0] <= face.tag_in;
    end
  end

  // Stage 1: six signed products
  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      prod[0]  <= PROD_W'(e1y * e2z);
      prod[1]  <= PROD_W'(e2y * e1z);
      prod[2]  <= PROD_W'(e2x * e1z);
      prod[3]  <= PROD_W'(e1x * e2z);
      prod[4]  <= PROD_W'(e1x * e2y);
      prod[5]  <= PROD_W'(e2x * e1y);
      tag_s[1] <= tag_s[0];
    end
  end

  // Stage 2: cross components
  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      for (int i = 0; i < 3; i++) begin
        cdiff[i] <= CROSS_W'(prod[2*i]) - CROSS_W'(prod[2*i+1]);
      end
      tag_s[2] <= tag_s[1];
    end
  end

  // Stage 3: sign and magnitude
  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      for (int i = 0; i < 3; i++) begin
        mag[i] <= cdiff[i][CROSS_W-1] ? CROSS_W'(-cdiff[i]) : CROSS_W'(cdiff[i]);
        neg[i] <= cdiff[i][CROSS_W-1];
      end
      tag_s[3] <= tag_s[2];
    end
  end

  assign tag      = tag_s[NS-1];
  assign up_ready = rdy[0];
  assign dn_valid = vld[NS-1];

endmodule

// ----- hw/rtl/fnu_norm.sv -----
// ----------------------------------------------------------------------------
// fnu_norm
// Common block-float scaling of the cross magnitudes and the sum of
// squares that feeds the square root; five stages.
// ----------------------------------------------------------------------------
module fnu_norm (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             up_valid,
  output logic                             up_ready,
  input  logic [2:0][fnu_pkg::CROSS_W-1:0] mag,
  input  logic [2:0]                       neg,
  input  logic [fnu_pkg::TAG_BITS-1:0]     tag,
  output logic                             dn_valid,
  input  logic                             dn_ready,
  output logic [fnu_pkg::SUM_W-1:0]        sum,
  output fnu_pkg::side_t                   side
);
  import fnu_pkg::*;

  localparam int NS = 5;

  logic [NS-1:0] vld;
  logic [NS:0]   rdy;
  logic [NS-1:0] vin;

  logic [2:0][CROSS_W-1:0] mag0, mag1;
  logic [2:0]              neg0, neg1;
  logic [TAG_BITS-1:0]     tag0, tag1;
  logic [TOP_W-1:0]        blen [3];
  logic [TOP_W-1:0]        top;
  side_t                   side2, side3, side4;
  logic [SQ_W-1:0]         sq [3];

  always_comb begin
    rdy[NS] = dn_ready;
    for (int k = NS - 1; k >= 0; k--) begin
      rdy[k] = ~vld[k] | rdy[k+1];
    end
  end

  assign vin = {vld[NS-2:0], up_valid};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (rdy[k]) begin
          vld[k] <= vin[k];
        end
      end
    end
  end

  // Stage 0: bit length of each magnitude
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      for (int i = 0; i < 3; i++) begin
        blen[i] <= bitlen(mag[i]);
      end
      mag0 <= mag;
      neg0 <= neg;
      tag0 <= tag;
    end
  end

  // Stage 1: largest bit length
  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      if (blen[0] >= blen[1] && blen[0] >= blen[2]) begin
        top <= blen[0];
      end else if (blen[1] >= blen[2]) begin
        top <= blen[1];
      end else begin
        top <= blen[2];
      end
      mag1 <= mag0;
      neg1 <= neg0;
      tag1 <= tag0;
    end
  end

  // Stage 2: shift all three by the same amount
  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      for (int i = 0; i < 3; i++) begin
        side2.a[i] <= scale_mag(mag1[i], top);
      end
      side2.neg   <= neg1;
      side2.tag   <= tag1;
      side2.degen <= (top == '0);
    end
  end

  // Stage 3: squares
  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      for (int i = 0; i < 3; i++) begin
        sq[i] <= SQ_W'(side2.a[i] * side2.a[i]);
      end
      side3 <= side2;
    end
  end

  // Stage 4: sum of squares
  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      sum   <= SUM_W'(sq[0]) + SUM_W'(sq[1]) + SUM_W'(sq[2]);
      side4 <= side3;
    end
  end

  assign side     = side4;
  assign up_ready = rdy[0];
  assign dn_valid = vld[NS-1];

endmodule

// ----- hw/rtl/fnu_sqrt.sv -----
// ----------------------------------------------------------------------------
// fnu_sqrt
// Pipelined restoring integer square root, SQ_PER result bits per stage.
// ----------------------------------------------------------------------------
module fnu_sqrt (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      up_valid,
  output logic                      up_ready,
  input  logic [fnu_pkg::SUM_W-1:0] sum,
  input  fnu_pkg::side_t            side,
  output logic                      dn_valid,
  input  logic                      dn_ready,
  output logic [fnu_pkg::LEN_W-1:0] len,
  output fnu_pkg::side_t            side_out
);
  import fnu_pkg::*;

  localparam int NS = SQ_STAGES;

  logic [NS-1:0] vld;
  logic [NS:0]   rdy;
  logic [NS-1:0] vin;

  sqrt_st_t st  [NS];
  sqrt_st_t src [NS];
  sqrt_st_t res [NS];

  always_comb begin
    rdy[NS] = dn_ready;
    for (int k = NS - 1; k >= 0; k--) begin
      rdy[k] = ~vld[k] | rdy[k+1];
    end
  end

  assign vin = {vld[NS-2:0], up_valid};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (rdy[k]) begin
          vld[k] <= vin[k];
        end
      end
    end
  end

  // Stage inputs: the first stage starts from the raw sum
  for (genvar k = 0; k < NS; k++) begin : g_src
    if (k == 0) begin : g_head
      assign src[k] = '{rad: RAD_W'(sum), rem: '0, root: '0, side: side};
    end else begin : g_body
      assign src[k] = st[k-1];
    end
  end

  // Digit steps of each stage
  always_comb begin
    sqrt_st_t t;
    for (int k = 0; k < NS; k++) begin
      t = src[k];
      for (int j = 0; j < SQ_PER; j++) begin
        t = sqrt_step(t);
      end
      res[k] = t;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NS; k++) begin
      if (rdy[k]) begin
        st[k] <= res[k];
      end
    end
  end

  assign len      = st[NS-1].root[LEN_W-1:0];
  assign side_out = st[NS-1].side;
  assign up_ready = rdy[0];
  assign dn_valid = vld[NS-1];

endmodule

// ----- hw/rtl/fnu_div.sv -----
// ----------------------------------------------------------------------------
// fnu_div
// Three-lane pipelined divide a*2^15/len, saturation, sign, the axis tag
// rules and the output register.
// ----------------------------------------------------------------------------
module fnu_div (
  input  logic                                              clk,
  input  logic                                              rst,
  input  logic                                              up_valid,
  output logic                                              up_ready,
  input  logic [fnu_pkg::LEN_W-1:0]                         len,
  input  fnu_pkg::side_t                                    side,
  input  logic [fnu_pkg::NUM_RULES-1:0][fnu_pkg::TAG_BITS-1:0] overrides,
  output logic                                              dn_valid,
  input  logic                                              dn_ready,
  output fnu_pkg::face_out_t                                result
);
  import fnu_pkg::*;

  localparam int NS = DIV_STAGES + 1;  // divide stages plus output register

  logic [NS-1:0] vld;
  logic [NS:0]   rdy;
  logic [NS-1:0] vin;

  div_st_t   st  [DIV_STAGES];
  div_st_t   src [DIV_STAGES];
  div_st_t   res [DIV_STAGES];
  face_out_t fin;
  face_out_t out_reg;

  always_comb begin
    rdy[NS] = dn_ready;
    for (int k = NS - 1; k >= 0; k--) begin
      rdy[k] = ~vld[k] | rdy[k+1];
    end
  end

  assign vin = {vld[NS-2:0], up_valid};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (rdy[k]) begin
          vld[k] <= vin[k];
        end
      end
    end
  end

  // Stage inputs: remainder starts at the scaled magnitude
  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_src
    if (k == 0) begin : g_head
      always_comb begin
        src[k]      = '0;
        src[k].len  = len;
        src[k].side = side;
        for (int i = 0; i < 3; i++) begin
          src[k].r[i] = R_W'(side.a[i]);
        end
      end
    end else begin : g_body
      assign src[k] = st[k-1];
    end
  end

  always_comb begin
    div_st_t t;
    for (int k = 0; k < DIV_STAGES; k++) begin
      t = src[k];
      for (int j = 0; j < DIV_PER; j++) begin
        t = div_step(t);
      end
      res[k] = t;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < DIV_STAGES; k++) begin
      if (rdy[k]) begin
        st[k] <= res[k];
      end
    end
  end

  // Final: saturate, apply sign, run the six axis rules in order
  always_comb begin
    logic [Q_W-1:0]      qs [3];
    logic [Q_W-1:0]      sv [3];
    logic [TAG_BITS-1:0] t;
    div_st_t             d;
    d = st[DIV_STAGES-1];
    for (int i = 0; i < 3; i++) begin
      qs[i] = (d.q[i] > Q15_MAX) ? Q15_MAX : d.q[i];
      sv[i] = (d.side.neg[i] && qs[i] != '0) ? Q_W'(~qs[i] + 1'b1) : qs[i];
    end
    t = d.side.tag;
    if (t != '0) begin
      for (int i = 0; i < NUM_RULES; i++) begin
        // even rules look for the negative direction
        if (overrides[i] != '0 && qs[i/2] >= BEYOND_THRESH &&
            d.side.neg[i/2] == ((i % 2) == 0)) begin
          t = overrides[i];
        end
      end
    end
    if (d.side.degen) begin
      fin.unit_nx    = '0;
      fin.unit_ny    = '0;
      fin.unit_nz    = '0;
      fin.tag_out    = d.side.tag;
      fin.degenerate = 1'b1;
    end else begin
      fin.unit_nx    = sv[0];
      fin.unit_ny    = sv[1];
      fin.unit_nz    = sv[2];
      fin.tag_out    = t;
      fin.degenerate = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[NS-1]) begin
      out_reg <= fin;
    end
  end

  assign result   = out_reg;
  assign up_ready = rdy[0];
  assign dn_valid = vld[NS-1];

endmodule

// ----- hw/rtl/face_unit_normal_bc_tagger.sv -----
// ----------------------------------------------------------------------------
// face_unit_normal_bc_tagger
// Unit normal of a triangle face in Q1.15 with axis-driven boundary tag
// override.
// ----------------------------------------------------------------------------
//  channel  | signals                         | beat
//  ---------+---------------------------------+------------------------------
//  face     | face_valid, face_stall, face    | three vertices and tag_in
//  norm     | norm_valid, norm_stall, norm    | unit normal, tag_out, flag
//  cfg      | cfg_we, cfg_index, cfg_data     | one override register write
//
//  One face per clock sustained while norm_stall stays low; stages: 4 cross,
//  5 scaling, 16 square root, 8 divide, 1 output register, with the root and
//  divide pipelines at two result bits per stage.
//  Reset clears all valid bits and the override registers.
//  Each stage holds under stall only while it is full; bubbles close up,
//  so face_stall rises only when every stage holds a beat.
// ----------------------------------------------------------------------------
module face_unit_normal_bc_tagger (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              face_valid,
  output logic                              face_stall,
  input  fnu_pkg::face_in_t                 face,
  output logic                              norm_valid,
  input  logic                              norm_stall,
  output fnu_pkg::face_out_t                norm,
  input  logic                              cfg_we,
  input  logic [fnu_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [fnu_pkg::TAG_BITS-1:0]      cfg_data
);
  import fnu_pkg::*;

  logic [NUM_RULES-1:0][TAG_BITS-1:0] override_reg;

  logic                    cross_ready, cross_valid;
  logic [2:0][CROSS_W-1:0] cross_mag;
  logic [2:0]              cross_neg;
  logic [TAG_BITS-1:0]     cross_tag;

  logic                    norm_ready, scale_valid;
  logic [SUM_W-1:0]        scale_sum;
  side_t                   scale_side;

  logic                    sqrt_ready, sqrt_valid;
  logic [LEN_W-1:0]        sqrt_len;
  side_t                   sqrt_side;

  logic                    div_ready;

  // Override registers; writes past the last rule are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      override_reg <= '0;
    end else if (cfg_we && cfg_index < CFG_IDX_W'(NUM_RULES)) begin
      override_reg[cfg_index] <= cfg_data;
    end
  end

  fnu_cross u_cross (
    .clk      (clk),
    .rst      (rst),
    .up_valid (face_valid),
    .up_ready (cross_ready),
    .face     (face),
    .dn_valid (cross_valid),
    .dn_ready (norm_ready),
    .mag      (cross_mag),
    .neg      (cross_neg),
    .tag      (cross_tag)
  );

  fnu_norm u_norm (
    .clk      (clk),
    .rst      (rst),
    .up_valid (cross_valid),
    .up_ready (norm_ready),
    .mag      (cross_mag),
    .neg      (cross_neg),
    .tag      (cross_tag),
    .dn_valid (scale_valid),
    .dn_ready (sqrt_ready),
    .sum      (scale_sum),
    .side     (scale_side)
  );

  fnu_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .up_valid (scale_valid),
    .up_ready (sqrt_ready),
    .sum      (scale_sum),
    .side     (scale_side),
    .dn_valid (sqrt_valid),
    .dn_ready (div_ready),
    .len      (sqrt_len),
    .side_out (sqrt_side)
  );

  fnu_div u_div (
    .clk       (clk),
    .rst       (rst),
    .up_valid  (sqrt_valid),
    .up_ready  (div_ready),
    .len       (sqrt_len),
    .side      (sqrt_side),
    .overrides (override_reg),
    .dn_valid  (norm_valid),
    .dn_ready  (~norm_stall),
    .result    (norm)
  );

  assign face_stall = ~cross_ready;

endmodule

// ----- hw/rtl/fnu_checker.sv -----
// ----------------------------------------------------------------------------
// fnu_checker
// Port-level checks on the result channel of the unit-normal tagger.
// ----------------------------------------------------------------------------
module fnu_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          face_stall,
  input logic                          norm_valid,
  input logic                          norm_stall,
  input fnu_pkg::face_out_t            norm
);
  import fnu_pkg::*;

  // A held result beat keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    norm_valid && norm_stall |=> norm_valid && $stable(norm))
    else $error("result beat changed while stalled");

  // Input stalls only when the result side is full and stalled
  a_stall_src: assert property (@(posedge clk) disable iff (rst)
    face_stall |-> norm_valid && norm_stall)
    else $error("face stalled while the result side can drain");

  // Degenerate faces carry a zero normal
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    norm_valid && norm.degenerate |->
      norm.unit_nx == '0 && norm.unit_ny == '0 && norm.unit_nz == '0)
    else $error("degenerate face with nonzero normal");

  // Saturation keeps every component off the most negative code
  a_no_min: assert property (@(posedge clk) disable iff (rst)
    norm_valid |-> norm.unit_nx != 16'sh8000 && norm.unit_ny != 16'sh8000 &&
                   norm.unit_nz != 16'sh8000)
    else $error("normal component at most negative code");

  // A unit vector has at least one component of magnitude at least one half
  a_unit_len: assert property (@(posedge clk) disable iff (rst)
    norm_valid && !norm.degenerate |->
      norm.unit_nx >= 16'sd16384 || norm.unit_nx <= -16'sd16384 ||
      norm.unit_ny >= 16'sd16384 || norm.unit_ny <= -16'sd16384 ||
      norm.unit_nz >= 16'sd16384 || norm.unit_nz <= -16'sd16384)
    else $error("normal too short for a unit vector");

endmodule

bind face_unit_normal_bc_tagger fnu_checker u_fnu_checker (
  .clk        (clk),
  .rst        (rst),
  .face_stall (face_stall),
  .norm_valid (norm_valid),
  .norm_stall (norm_stall),
  .norm       (norm)
);
